@@ hdl/mcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, sizes and bond threshold tables for the molecule
// connectivity check.
// ----------------------------------------------------------------------------
package mcc_pkg;

   // default atom capacity
   localparam int MaxAtomsDefault = 64;

   // squared distances are in units of 2^-20 square angstrom
   localparam longint BondScale = 10000;
   localparam int     ThrW      = 22;
   localparam int     D2W       = 34;

   // element codes
   localparam logic [2:0] ELEM_C     = 3'd0;
   localparam logic [2:0] ELEM_H     = 3'd1;
   localparam logic [2:0] ELEM_O     = 3'd2;
   localparam logic [2:0] ELEM_N     = 3'd3;
   localparam logic [2:0] ELEM_OTHER = 3'd4;

   typedef struct packed {
      logic [2:0]         element_code;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] z_pos;
      logic               last_atom;
   } req_type;

   typedef struct packed {
      logic       dissociated;
      logic [6:0] atom_total;
      logic       overflow;
   } rsp_type;

   // one stored atom
   typedef struct packed {
      logic [2:0]         element_code;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] z_pos;
   } store_type;

   // classified atom handed from the front to the back
   typedef struct packed {
      store_type pos;
      logic      known;
      logic      last;
   } atom_type;

   // d2 * 10000 > p^2 * 2^20  <=>  d2 > floor(p^2 * 2^20 / 10000)
   function automatic logic [ThrW-1:0] thr_floor(input longint p);
      longint full;
      full = (p * p) << 20;
      return ThrW'(full / BondScale);
   endfunction

   // d2 * 10000 < p^2 * 2^20  <=>  d2 < ceil(p^2 * 2^20 / 10000)
   function automatic logic [ThrW-1:0] thr_ceil(input longint p);
      longint full;
      full = (p * p) << 20;
      return ThrW'((full + BondScale - 1) / BondScale);
   endfunction

   // indexed by {first element, second element}, bounds in 0.01 angstrom
   localparam logic [ThrW-1:0] BondLoTable [16] = '{
      thr_floor(114), thr_floor(102), thr_floor(120), thr_floor(140),
      thr_floor(102), thr_floor(57),  thr_floor(91),  thr_floor(95),
      thr_floor(120), thr_floor(91),  thr_floor(110), thr_floor(114),
      thr_floor(140), thr_floor(95),  thr_floor(114), thr_floor(104)
   };

   localparam logic [ThrW-1:0] BondHiTable [16] = '{
      thr_ceil(162), thr_ceil(112), thr_ceil(150), thr_ceil(154),
      thr_ceil(112), thr_ceil(63),  thr_ceil(101), thr_ceil(105),
      thr_ceil(150), thr_ceil(101), thr_ceil(139), thr_ceil(126),
      thr_ceil(154), thr_ceil(105), thr_ceil(126), thr_ceil(114)
   };

endpackage

@@ hdl/mcc_front.sv @@
// ----------------------------------------------------------------------------
// mcc_front
// Accepts atom words, tags whether the element has bond data and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mcc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mcc_pkg::req_type  req_data,
   output logic              atom_valid,
   output mcc_pkg::atom_type atom_data,
   input  logic              atom_pop
);
   import mcc_pkg::*;

   atom_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   atom_type   incoming;

   // classify the incoming word
   always_comb begin
      incoming.pos.element_code = req_data.element_code;
      incoming.pos.x_pos        = req_data.x_pos;
      incoming.pos.y_pos        = req_data.y_pos;
      incoming.pos.z_pos        = req_data.z_pos;
      incoming.known            = (req_data.element_code <= ELEM_N);
      incoming.last             = req_data.last_atom;
   end

   assign busy       = (fill_ff == 2'd2);
   assign push       = start && !busy;
   assign atom_valid = (fill_ff != 2'd0);
   assign atom_data  = queue_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = atom_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(atom_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

@@ hdl/mcc_back.sv @@
// ----------------------------------------------------------------------------
// mcc_back
// Stores atoms, tests the new atom against each stored one, merges the
// touched components and, on the last atom, checks connectivity.
// ----------------------------------------------------------------------------
module mcc_back #(
   parameter int MAX_ATOMS = mcc_pkg::MaxAtomsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              atom_valid,
   input  mcc_pkg::atom_type atom_data,
   output logic              atom_pop,
   output logic              rsp_strobe,
   output mcc_pkg::rsp_type  rsp_data
);
   import mcc_pkg::*;

   localparam int AW = $clog2(MAX_ATOMS);
   localparam int CW = $clog2(MAX_ATOMS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;
   localparam logic [1:0] ST_CHECK = 2'd3;

   // memories
   store_type atom_mem [MAX_ATOMS];
   logic [AW-1:0] lab_mem [MAX_ATOMS];
   store_type     atom_rd_ff;
   logic [AW-1:0] lab_rd_ff;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   atom_type      cur_ff, cur_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          diss_ff, diss_in;
   logic [AW-1:0] ref_ff;
   logic [MAX_ATOMS-1:0] mask_ff;

   // pair test pipeline
   logic                p1_v_ff, p2_v_ff;
   logic [32:0]         sqx_ff, sqy_ff, sqz_ff;
   logic                ok_ff;
   logic [ThrW-1:0]     lo_ff, hi_ff;
   logic [AW-1:0]       lab2_ff;
   logic                q_v_ff, c_v_ff, c_first_ff;
   logic [AW-1:0]       q_addr_ff;

   logic          accept, store, issue, drained, emit;
   logic [CW-1:0] issue_lim;
   logic          atom_we, lab_we;
   logic [AW-1:0] lab_wa, lab_wd;
   logic signed [16:0] dx, dy, dz;
   logic signed [33:0] px, py, pz;
   logic [3:0]         pair_idx;
   logic [D2W-1:0]     d2;
   logic               bonded;

   logic          rsp_strobe_ff;
   rsp_type       rsp_data_ff;

   assign accept   = (state_ff == ST_IDLE) && atom_valid;
   assign atom_pop = accept;
   assign store    = accept && (count_ff != CW'(MAX_ATOMS));
   assign issue_lim = (state_ff == ST_CHECK) ? count_ff : n_ff;
   assign issue    = (state_ff != ST_IDLE) && (idx_ff < issue_lim);

   // pipeline empty for the current pass
   always_comb begin
      case (state_ff)
         ST_SCAN:  drained = !issue && !p1_v_ff && !p2_v_ff;
         ST_MERGE: drained = !issue && !q_v_ff;
         ST_CHECK: drained = !issue && !c_v_ff;
         default:  drained = 1'b0;
      endcase
   end
   assign emit = (state_ff == ST_CHECK) && drained;

   // label memory write: new atom label on store, merge relabel otherwise
   always_comb begin
      atom_we = store;
      lab_we  = 1'b0;
      lab_wa  = count_ff[AW-1:0];
      lab_wd  = count_ff[AW-1:0];
      if (store) begin
         lab_we = 1'b1;
      end else if (state_ff == ST_MERGE && q_v_ff && mask_ff[lab_rd_ff]) begin
         lab_we = 1'b1;
         lab_wa = q_addr_ff;
         lab_wd = n_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (atom_we) begin
         atom_mem[count_ff[AW-1:0]] <= atom_data.pos;
      end
      atom_rd_ff <= atom_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_wa] <= lab_wd;
      end
      lab_rd_ff <= lab_mem[idx_ff[AW-1:0]];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      cur_in   = cur_ff;
      n_in     = n_ff;
      idx_in   = issue ? idx_ff + CW'(1) : idx_ff;
      diss_in  = diss_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in = atom_data;
               idx_in = '0;
               if (store) begin
                  n_in     = count_ff;
                  count_in = count_ff + CW'(1);
                  state_in = ST_SCAN;
               end else begin
                  ovf_in   = 1'b1;
                  diss_in  = 1'b0;
                  state_in = atom_data.last ? ST_CHECK : ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (drained) begin
               idx_in   = '0;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (drained) begin
               idx_in   = '0;
               diss_in  = 1'b0;
               state_in = cur_ff.last ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (c_v_ff && !c_first_ff && (lab_rd_ff != ref_ff)) begin
               diss_in = 1'b1;
            end
            if (drained) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         idx_ff        <= '0;
         p1_v_ff       <= 1'b0;
         p2_v_ff       <= 1'b0;
         q_v_ff        <= 1'b0;
         c_v_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         idx_ff        <= idx_in;
         p1_v_ff       <= issue && (state_ff == ST_SCAN);
         p2_v_ff       <= p1_v_ff;
         q_v_ff        <= issue && (state_ff == ST_MERGE);
         c_v_ff        <= issue && (state_ff == ST_CHECK);
         rsp_strobe_ff <= emit;
      end
   end

   // squares of the coordinate differences
   always_comb begin
      dx = $signed({cur_ff.pos.x_pos[15], cur_ff.pos.x_pos})
         - $signed({atom_rd_ff.x_pos[15], atom_rd_ff.x_pos});
      dy = $signed({cur_ff.pos.y_pos[15], cur_ff.pos.y_pos})
         - $signed({atom_rd_ff.y_pos[15], atom_rd_ff.y_pos});
      dz = $signed({cur_ff.pos.z_pos[15], cur_ff.pos.z_pos})
         - $signed({atom_rd_ff.z_pos[15], atom_rd_ff.z_pos});
      px = dx * dx;
      py = dy * dy;
      pz = dz * dz;
      pair_idx = {cur_ff.pos.element_code[1:0], atom_rd_ff.element_code[1:0]};
   end

   // bounds window test on the summed squares
   assign d2 = D2W'(sqx_ff) + D2W'(sqy_ff) + D2W'(sqz_ff);
   assign bonded = ok_ff && (d2 > D2W'(lo_ff)) && (d2 < D2W'(hi_ff));

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      n_ff       <= n_in;
      diss_ff    <= diss_in;
      sqx_ff     <= px[32:0];
      sqy_ff     <= py[32:0];
      sqz_ff     <= pz[32:0];
      ok_ff      <= cur_ff.known && (atom_rd_ff.element_code <= ELEM_N);
      lo_ff      <= BondLoTable[pair_idx];
      hi_ff      <= BondHiTable[pair_idx];
      lab2_ff    <= lab_rd_ff;
      q_addr_ff  <= idx_ff[AW-1:0];
      c_first_ff <= (idx_ff == '0);
      if (c_v_ff && c_first_ff) begin
         ref_ff <= lab_rd_ff;
      end
      // components touching the new atom
      if (accept) begin
         mask_ff <= '0;
      end else if (p2_v_ff && bonded) begin
         mask_ff[lab2_ff] <= 1'b1;
      end
      if (emit) begin
         rsp_data_ff.dissociated <= diss_in;
         rsp_data_ff.atom_total  <= 7'(count_ff);
         rsp_data_ff.overflow    <= ovf_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ hdl/molecule_connectivity_check_core.sv @@
// The back end gives an atom joining n stored atoms a scan pass and a merge pass over them;
// the last atom adds a label check over all stored atoms before the result.
// Throughput is set by the single read port of the atom and label memories.
// A two-word queue accepts atoms while the back end works; busy rises when it is full.
// Reset (synchronous, active high) clears the counters, flags and queue; memories keep data.
// Results are strobed for one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
// molecule_connectivity_check_core
// Builds the bond graph of a molecule atom by atom and reports whether it
// falls apart into more than one component.
// ----------------------------------------------------------------------------
module molecule_connectivity_check_core #(
   parameter int MAX_ATOMS = mcc_pkg::MaxAtomsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mcc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mcc_pkg::rsp_type rsp_data
);
   import mcc_pkg::*;

   logic     atom_valid;
   atom_type atom_data;
   logic     atom_pop;

   mcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .atom_valid (atom_valid),
      .atom_data  (atom_data),
      .atom_pop   (atom_pop)
   );

   mcc_back #(
      .MAX_ATOMS (MAX_ATOMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .atom_valid (atom_valid),
      .atom_data  (atom_data),
      .atom_pop   (atom_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
